// ===== src/gcco_pkg.sv =====
// Package with the shared types, codes and helper function of the greedy colour-class order core.
package gcco_pkg;

    localparam int VERTEX_W   = 6;
    localparam int COLOUR_W   = 7;
    localparam int SET_W      = 64;
    localparam int S_TDATA_W  = 200;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    // Bit positions of the input fields inside s_tdata.
    localparam int ROW_INDEX_LSB  = 0;
    localparam int ROW_BITS_LSB   = 6;
    localparam int CANDIDATES_LSB = 70;
    localparam int ALLOWED_LSB    = 134;

    localparam logic [1:0] MODE_LOAD      = 2'd0;
    localparam logic [1:0] MODE_PLAIN     = 2'd1;
    localparam logic [1:0] MODE_CONNECTED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_PICK,
        ST_MASK
    } state_t;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_IGNORE,
        KIND_EMPTY,
        KIND_COLOUR
    } item_kind_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic emit_empty;
        logic pick;
        logic mask;
    } ctrl_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       out_free;
        logic       pick_last;
    } dp_status_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [VERTEX_W-1:0] lowest_index(input logic [SET_W-1:0] x);
        logic [SET_W-1:0]    onehot;
        logic [VERTEX_W-1:0] idx;
        onehot = x & (~x + {{(SET_W-1){1'b0}}, 1'b1});
        idx = '0;
        for (int i = 0; i < SET_W; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | VERTEX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== src/gcco_ctrl.sv =====
// Controller state machine of the greedy colour-class order core.
module gcco_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  gcco_pkg::dp_status_t status,
    output gcco_pkg::ctrl_cmd_t  cmd
);

    gcco_pkg::state_t state_reg;
    gcco_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcco_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcco_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.kind == gcco_pkg::KIND_EMPTY)
                    begin
                        state_next = gcco_pkg::ST_EMPTY;
                    end
                    else if (status.kind == gcco_pkg::KIND_COLOUR)
                    begin
                        state_next = gcco_pkg::ST_PICK;
                    end
                end
            end
            gcco_pkg::ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = gcco_pkg::ST_IDLE;
                end
            end
            gcco_pkg::ST_PICK:
            begin
                if (status.out_free)
                begin
                    state_next = status.pick_last ? gcco_pkg::ST_IDLE : gcco_pkg::ST_MASK;
                end
            end
            gcco_pkg::ST_MASK:
            begin
                state_next = gcco_pkg::ST_PICK;
            end
            default:
            begin
                state_next = gcco_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            gcco_pkg::ST_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = s_tvalid;
            end
            gcco_pkg::ST_EMPTY:
            begin
                cmd.emit_empty = status.out_free;
            end
            gcco_pkg::ST_PICK:
            begin
                cmd.pick = status.out_free;
            end
            gcco_pkg::ST_MASK:
            begin
                cmd.mask = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/gcco_datapath.sv =====
// Datapath of the greedy colour-class order core: adjacency memory, vertex sets and result register.
module gcco_datapath #(
    parameter int VERTICES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [gcco_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [gcco_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gcco_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  gcco_pkg::ctrl_cmd_t                 cmd,
    output gcco_pkg::dp_status_t                status
);

    localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam logic [gcco_pkg::SET_W-1:0] VMASK =
        (VERTICES >= gcco_pkg::SET_W) ? {gcco_pkg::SET_W{1'b1}}
                                      : ((64'd1 << VERTICES) - 64'd1);

    logic [gcco_pkg::SET_W-1:0] adj_mem [VERTICES];
    logic [gcco_pkg::SET_W-1:0] rdata_reg;

    logic [gcco_pkg::SET_W-1:0]    unc_reg, unc_next;
    logic [gcco_pkg::SET_W-1:0]    pool_reg, pool_next;
    logic [gcco_pkg::SET_W-1:0]    second_reg, second_next;
    logic [gcco_pkg::COLOUR_W-1:0] colour_reg, colour_next;

    logic                          out_valid_reg;
    logic [gcco_pkg::VERTEX_W-1:0] out_vertex_reg;
    logic [gcco_pkg::COLOUR_W-1:0] out_colour_reg;
    logic                          out_last_reg;
    logic                          out_empty_reg;

    logic [1:0]                    mode;
    logic [gcco_pkg::VERTEX_W-1:0] row_index;
    logic [gcco_pkg::SET_W-1:0]    row_bits;
    logic [gcco_pkg::SET_W-1:0]    cand;
    logic [gcco_pkg::SET_W-1:0]    allow;
    logic [gcco_pkg::SET_W-1:0]    first_set;
    logic [gcco_pkg::SET_W-1:0]    second_set;
    logic                          row_in_range;
    logic                          load_we;
    gcco_pkg::item_kind_t          kind;

    logic [gcco_pkg::VERTEX_W-1:0] pick_v;
    logic [gcco_pkg::SET_W-1:0]    pick_bit;
    logic [gcco_pkg::SET_W-1:0]    unc_after;
    logic                          pick_last;
    logic [gcco_pkg::SET_W-1:0]    pool_masked;
    logic                          out_free;

    assign mode      = s_tuser;
    assign row_index = s_tdata[gcco_pkg::ROW_INDEX_LSB +: gcco_pkg::VERTEX_W];
    assign row_bits  = s_tdata[gcco_pkg::ROW_BITS_LSB +: gcco_pkg::SET_W] & VMASK;
    assign cand      = s_tdata[gcco_pkg::CANDIDATES_LSB +: gcco_pkg::SET_W] & VMASK;
    assign allow     = s_tdata[gcco_pkg::ALLOWED_LSB +: gcco_pkg::SET_W] & VMASK;

    assign row_in_range = ({1'b0, row_index} < 7'(VERTICES));

    always_comb
    begin
        unique case (mode)
            gcco_pkg::MODE_LOAD:
            begin
                kind       = gcco_pkg::KIND_LOAD;
                first_set  = '0;
                second_set = '0;
            end
            gcco_pkg::MODE_PLAIN:
            begin
                kind       = (cand == '0) ? gcco_pkg::KIND_EMPTY : gcco_pkg::KIND_COLOUR;
                first_set  = cand;
                second_set = '0;
            end
            gcco_pkg::MODE_CONNECTED:
            begin
                kind       = (cand == '0) ? gcco_pkg::KIND_EMPTY : gcco_pkg::KIND_COLOUR;
                first_set  = cand & ~allow;
                second_set = cand & allow;
            end
            default:
            begin
                kind       = gcco_pkg::KIND_IGNORE;
                first_set  = '0;
                second_set = '0;
            end
        endcase
    end

    assign load_we = cmd.accept && (kind == gcco_pkg::KIND_LOAD) && row_in_range;

    // Placement step: the lowest vertex left in the class pool joins the current class.
    assign pick_v    = gcco_pkg::lowest_index(pool_reg);
    assign pick_bit  = 64'd1 << pick_v;
    assign unc_after = unc_reg & ~pick_bit;
    assign pick_last = (unc_after == '0) && (second_reg == '0);

    assign pool_masked = pool_reg & ~rdata_reg;

    assign out_free = !out_valid_reg || m_tready;

    assign status = '{kind: kind, out_free: out_free, pick_last: pick_last};

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            adj_mem[row_index[AW-1:0]] <= row_bits;
        end
        if (cmd.pick)
        begin
            rdata_reg <= adj_mem[pick_v[AW-1:0]];
        end
    end

    always_comb
    begin
        unc_next    = unc_reg;
        pool_next   = pool_reg;
        second_next = second_reg;
        colour_next = colour_reg;
        priority if (cmd.accept && kind == gcco_pkg::KIND_COLOUR)
        begin
            colour_next = 7'd1;
            if (first_set != '0)
            begin
                unc_next    = first_set;
                pool_next   = first_set;
                second_next = second_set;
            end
            else
            begin
                unc_next    = second_set;
                pool_next   = second_set;
                second_next = '0;
            end
        end
        else if (cmd.accept && kind == gcco_pkg::KIND_EMPTY)
        begin
            unc_next    = '0;
            pool_next   = '0;
            second_next = '0;
            colour_next = '0;
        end
        else if (cmd.pick)
        begin
            unc_next  = unc_after;
            pool_next = pool_reg & ~pick_bit;
        end
        else if (cmd.mask)
        begin
            if (pool_masked != '0)
            begin
                pool_next = pool_masked;
            end
            else if (unc_reg != '0)
            begin
                pool_next   = unc_reg;
                colour_next = colour_reg + 7'd1;
            end
            else
            begin
                unc_next    = second_reg;
                pool_next   = second_reg;
                second_next = '0;
                colour_next = colour_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unc_reg       <= '0;
            pool_reg      <= '0;
            second_reg    <= '0;
            colour_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unc_reg    <= unc_next;
            pool_reg   <= pool_next;
            second_reg <= second_next;
            colour_reg <= colour_next;
            if (cmd.pick || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            out_vertex_reg <= pick_v;
            out_colour_reg <= colour_reg;
            out_last_reg   <= pick_last;
            out_empty_reg  <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            out_vertex_reg <= '0;
            out_colour_reg <= '0;
            out_last_reg   <= 1'b1;
            out_empty_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_colour_reg, out_vertex_reg};
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/greedy_colour_class_order_core.sv =====
// Top level of the greedy colour-class order core.
//
// This core stores an undirected graph of up to VERTICES vertices as one adjacency row per
// vertex and, for each colouring transfer, splits the candidate set greedily into colour
// classes: every class is filled by repeatedly taking the lowest-numbered vertex left in the
// class pool and striking it and its neighbours from that pool. One (vertex, colour) result
// transfer leaves per candidate in placement order, tlast marks the final one, and an empty
// candidate set yields a single result with tuser set and vertex and colour zero. In connected
// mode the candidates outside the allowed set are coloured first, then those inside it, with
// colour numbers carrying on across both phases. A load transfer gives no result. A colouring
// steps through each candidate vertex as the acceptance step or a mask step, followed by a
// placement step, and a full output register can hold a placement back. Each placement
// reads the chosen vertex's adjacency row from a single-port memory with a registered read,
// and the next placement needs the pool masked by that row. The core works on one colouring
// at a time; it takes the next input transfer as soon as the last result sits in the output
// register, even while that result still waits.
// Reading the row of a vertex that was never loaded gives an undefined class split.
module greedy_colour_class_order_core #(
    parameter int VERTICES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, lowest bit up: row_index[5:0], row_bits[69:6], candidates[133:70],
    // allowed[197:134], zero padding[199:198].
    input  logic [gcco_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: mode[1:0] (0 load row, 1 plain colouring, 2 connected colouring).
    input  logic [gcco_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, lowest bit up: vertex[5:0], colour[12:6], zero padding[15:13].
    output logic [gcco_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: empty_set[0].
    output logic                               m_tuser,
    output logic                               m_tlast
);

    gcco_pkg::ctrl_cmd_t  cmd;
    gcco_pkg::dp_status_t status;

    // The controller sequences acceptance, placement and masking steps.
    gcco_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the adjacency rows, the vertex sets and the result register.
    gcco_datapath #(
        .VERTICES (VERTICES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

    assign s_tready = cmd.ready;

endmodule

// ===== src/gcco_checker.sv =====
// Port-level checker of the greedy colour-class order core and its bind statement.
module gcco_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [gcco_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic [gcco_pkg::S_TUSER_W-1:0]     s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [gcco_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tuser,
    input logic                               m_tlast
);

    // A waiting input transfer is held until the core takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input transfer changed");

    // A stalled result holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty-set result is always the final one of its colouring.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("empty-set result without last");

    // An empty-set result carries vertex 0 and colour 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty-set result with nonzero payload");

    // A placed vertex always belongs to a numbered colour class.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[12:6] != 7'd0)
        else $error("placed vertex with colour 0");

endmodule

bind greedy_colour_class_order_core gcco_checker u_gcco_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the greedy colour-class order core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names the three live modes; the remaining code is ignored by the core.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         NVERT       = 64;
    localparam int         MAX_STALL   = 16;
    localparam int         DRAIN_CYCLES = 2 * NVERT + 32;

    // One input transfer as the stimulus generator sees it.
    typedef struct {
        logic [1:0]                    mode;
        logic [gcco_pkg::VERTEX_W-1:0] row_index;
        logic [gcco_pkg::SET_W-1:0]    row_bits;
        logic [gcco_pkg::SET_W-1:0]    candidates;
        logic [gcco_pkg::SET_W-1:0]    allowed;
    } graph_cmd_t;

    // One predicted (vertex, colour) placement.
    typedef struct {
        logic [gcco_pkg::VERTEX_W-1:0] vertex;
        logic [gcco_pkg::COLOUR_W-1:0] colour;
        logic                          is_last;
        logic                          empty_set;
    } placement_t;

    logic                           clk    = 1'b0;
    logic                           rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gcco_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [gcco_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gcco_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    greedy_colour_class_order_core #(
        .VERTICES (NVERT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Stimulus not yet handed to the core, and placements not yet seen at the output.
    graph_cmd_t  pending_cmds[$];
    placement_t  expected_order[$];

    // The predictor's own copy of the graph and of the colouring registers.
    logic [gcco_pkg::SET_W-1:0]    graph_rows [NVERT];
    logic [gcco_pkg::SET_W-1:0]    uncoloured;
    logic [gcco_pkg::SET_W-1:0]    class_pool;
    logic [gcco_pkg::COLOUR_W-1:0] colour_num;

    // Rows written so far, in stimulus order; candidates are kept inside this set so that
    // the core never reads a row that was never loaded.
    logic [gcco_pkg::SET_W-1:0] rows_loaded = '0;

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned loads_done    = 0;
    int unsigned colourings    = 0;
    int unsigned empty_sets    = 0;
    int unsigned top_colour    = 0;

    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned src_gap   = 0;
    bit          src_burst = 1'b0;
    int unsigned sink_wait = 0;
    bit          sink_burst = 1'b0;

    function automatic logic [gcco_pkg::SET_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Gap before the next transfer; a burst stretch never idles.
    function automatic int unsigned draw_wait(input bit burst);
        if (burst)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_STALL);
    endfunction

    // Greedy split of one phase set into colour classes, appending to the expected order.
    task automatic colour_phase_predict(input logic [gcco_pkg::SET_W-1:0] phase_set);
        placement_t p;
        int         v;
        uncoloured = phase_set;
        while (uncoloured != '0)
        begin
            colour_num = colour_num + 1'b1;
            class_pool = uncoloured;
            while (class_pool != '0)
            begin
                v = 0;
                while (!class_pool[v])
                begin
                    v++;
                end
                uncoloured[v] = 1'b0;
                class_pool[v] = 1'b0;
                // A self loop in the row has no further effect: the vertex is already gone.
                class_pool = class_pool & ~graph_rows[v];
                p.vertex    = gcco_pkg::VERTEX_W'(v);
                p.colour    = colour_num;
                p.is_last   = 1'b0;
                p.empty_set = 1'b0;
                expected_order.insert(expected_order.size(), p);
            end
        end
    endtask

    // Prediction for one accepted input transfer.
    task automatic predict_colour_order(input graph_cmd_t cmd);
        placement_t p;
        if (cmd.mode == gcco_pkg::MODE_LOAD)
        begin
            graph_rows[cmd.row_index] = cmd.row_bits;
            loads_done++;
            return;
        end
        if (cmd.mode != gcco_pkg::MODE_PLAIN && cmd.mode != gcco_pkg::MODE_CONNECTED)
        begin
            return;
        end
        colourings++;
        colour_num = '0;
        if (cmd.candidates == '0)
        begin
            uncoloured  = '0;
            class_pool  = '0;
            p.vertex    = '0;
            p.colour    = '0;
            p.is_last   = 1'b1;
            p.empty_set = 1'b1;
            expected_order.insert(expected_order.size(), p);
            empty_sets++;
            return;
        end
        if (cmd.mode == gcco_pkg::MODE_PLAIN)
        begin
            colour_phase_predict(cmd.candidates);
        end
        else
        begin
            // Vertices outside the allowed set go first, numbering carries on afterwards.
            colour_phase_predict(cmd.candidates & ~cmd.allowed);
            colour_phase_predict(cmd.candidates & cmd.allowed);
        end
        expected_order[expected_order.size() - 1].is_last = 1'b1;
    endtask

    // Stimulus helpers used by the sequence below.
    task automatic queue_load(input int row, input logic [gcco_pkg::SET_W-1:0] bits);
        graph_cmd_t c;
        c.mode       = gcco_pkg::MODE_LOAD;
        c.row_index  = gcco_pkg::VERTEX_W'(row);
        c.row_bits   = bits;
        c.candidates = rand64();
        c.allowed    = rand64();
        pending_cmds.insert(pending_cmds.size(), c);
        rows_loaded[row] = 1'b1;
    endtask

    task automatic queue_colour(input logic [1:0] mode,
                                input logic [gcco_pkg::SET_W-1:0] cand,
                                input logic [gcco_pkg::SET_W-1:0] allow);
        graph_cmd_t c;
        c.mode       = mode;
        c.row_index  = gcco_pkg::VERTEX_W'($urandom_range(0, NVERT - 1));
        c.row_bits   = rand64();
        c.candidates = (mode == MODE_UNUSED) ? cand : (cand & rows_loaded);
        c.allowed    = allow;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Row contents range from empty through sparse to complete.
    function automatic logic [gcco_pkg::SET_W-1:0] random_row();
        case ($urandom_range(0, 6))
            0: return rand64();
            1: return rand64() & rand64();
            2: return rand64() & rand64() & rand64() & rand64();
            3: return {{(gcco_pkg::SET_W-1){1'b0}}, 1'b1} << $urandom_range(0, NVERT - 1);
            4: return '0;
            5: return '1;
            default: return rand64() | rand64();
        endcase
    endfunction

    function automatic logic [gcco_pkg::SET_W-1:0] random_candidates();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return {{(gcco_pkg::SET_W-1){1'b0}}, 1'b1} << $urandom_range(0, NVERT - 1);
            3: return rand64() & rand64();
            4: return rand64() & rand64() & rand64();
            5: return rand64() | rand64();
            default: return rand64();
        endcase
    endfunction

    function automatic logic [gcco_pkg::SET_W-1:0] random_allowed(
        input logic [gcco_pkg::SET_W-1:0] cand);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return ~cand;
            3: return cand;
            default: return rand64();
        endcase
    endfunction

    // Input side: record each transfer at the rising edge and feed it to the predictor.
    always @(posedge clk)
    begin : capture_input
        graph_cmd_t c;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            c.mode       = s_tuser;
            c.row_index  = s_tdata[gcco_pkg::ROW_INDEX_LSB +: gcco_pkg::VERTEX_W];
            c.row_bits   = s_tdata[gcco_pkg::ROW_BITS_LSB +: gcco_pkg::SET_W];
            c.candidates = s_tdata[gcco_pkg::CANDIDATES_LSB +: gcco_pkg::SET_W];
            c.allowed    = s_tdata[gcco_pkg::ALLOWED_LSB +: gcco_pkg::SET_W];
            predict_colour_order(c);
        end
    end

    // Driver: presents the next pending command after its drawn gap, holding it until taken.
    always @(negedge clk)
    begin : drive_input
        graph_cmd_t                     c;
        logic [gcco_pkg::S_TDATA_W-1:0] word;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !in_taken)
        begin
            // Still waiting for the core to take the current transfer.
        end
        else if (src_gap != 0)
        begin
            src_gap  <= src_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (pending_cmds.size() != 0)
        begin
            c = pending_cmds.pop_front();
            word = '0;
            word[gcco_pkg::ROW_INDEX_LSB +: gcco_pkg::VERTEX_W] = c.row_index;
            word[gcco_pkg::ROW_BITS_LSB +: gcco_pkg::SET_W]     = c.row_bits;
            word[gcco_pkg::CANDIDATES_LSB +: gcco_pkg::SET_W]   = c.candidates;
            word[gcco_pkg::ALLOWED_LSB +: gcco_pkg::SET_W]      = c.allowed;
            s_tdata  <= word;
            s_tuser  <= c.mode;
            s_tvalid <= 1'b1;
            if ($urandom_range(0, 15) == 0)
            begin
                src_burst <= !src_burst;
            end
            src_gap <= draw_wait(src_burst);
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Output side: compare every result transfer with the oldest expected placement.
    always @(posedge clk)
    begin : check_output
        placement_t                    exp_p;
        logic [gcco_pkg::VERTEX_W-1:0] got_vertex;
        logic [gcco_pkg::COLOUR_W-1:0] got_colour;
        out_taken <= rst_n && m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_vertex = m_tdata[0 +: gcco_pkg::VERTEX_W];
            got_colour = m_tdata[gcco_pkg::VERTEX_W +: gcco_pkg::COLOUR_W];
            results_seen++;
            if (int'(got_colour) > top_colour)
            begin
                top_colour = got_colour;
            end
            if (expected_order.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] unexpected result: vertex %0d colour %0d last %0b empty %0b",
                             $realtime, got_vertex, got_colour, m_tlast, m_tuser);
                end
            end
            else
            begin
                exp_p = expected_order.pop_front();
                if (got_vertex !== exp_p.vertex || got_colour !== exp_p.colour ||
                    m_tlast !== exp_p.is_last || m_tuser !== exp_p.empty_set)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] mismatch: expected vertex %0d colour %0d last %0b empty %0b",
                                 $realtime, exp_p.vertex, exp_p.colour, exp_p.is_last,
                                 exp_p.empty_set);
                        $display("          actual   vertex %0d colour %0d last %0b empty %0b",
                                 got_vertex, got_colour, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    // Receiver: after each result transfer, hold tready low for a drawn number of cycles.
    always @(negedge clk)
    begin : drive_ready
        int unsigned w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (out_taken)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                sink_burst <= !sink_burst;
            end
            w = draw_wait(sink_burst);
            if (w == 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready  <= 1'b0;
                sink_wait <= w - 1;
            end
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [gcco_pkg::SET_W-1:0] cand;
        logic [gcco_pkg::SET_W-1:0] probe;
        int                         pick;

        // Directed part: a handful of rows, then the corner cases of colouring.
        queue_load(0, '1);                                   // complete row with a self loop
        queue_load(1, '0);                                   // isolated vertex
        queue_load(2, 64'h8000_0000_0000_0004);              // self loop plus vertex 63
        queue_load(63, 64'h8000_0000_0000_0001);             // neighbours 0 and itself
        queue_load(5, 64'hAAAA_AAAA_AAAA_AAAA);
        probe = 64'h8000_0000_0000_0027;                     // vertices 0, 1, 2, 5, 63
        queue_colour(gcco_pkg::MODE_PLAIN, '0, '0);          // empty candidate set
        queue_colour(gcco_pkg::MODE_CONNECTED, '0, '1);
        queue_colour(gcco_pkg::MODE_PLAIN, 64'h2, '0);       // single vertex
        queue_colour(gcco_pkg::MODE_PLAIN, probe, rand64());
        queue_colour(gcco_pkg::MODE_CONNECTED, probe, 64'h8000_0000_0000_0002);
        queue_colour(gcco_pkg::MODE_CONNECTED, probe, '0);   // everything in the first phase
        queue_colour(gcco_pkg::MODE_CONNECTED, probe, '1);   // everything in the second phase
        queue_colour(MODE_UNUSED, '1, '1);                   // ignored mode
        queue_load(1, '1);                                   // rewrite a row
        queue_colour(gcco_pkg::MODE_PLAIN, probe, '0);
        queue_colour(gcco_pkg::MODE_CONNECTED, probe, 64'h21);

        // Complete graph: the full set needs one colour per vertex, up to the top number.
        for (int r = 0; r < NVERT; r++)
        begin
            queue_load(r, '1);
        end
        queue_colour(gcco_pkg::MODE_PLAIN, '1, '0);
        queue_colour(gcco_pkg::MODE_CONNECTED, '1, rand64());

        // Fresh random graph over every row, then a random mix of loads and colourings.
        for (int r = 0; r < NVERT; r++)
        begin
            queue_load(r, random_row());
        end
        for (int n = 0; n < 110; n++)
        begin
            pick = $urandom_range(0, 19);
            cand = random_candidates();
            if (pick < 5)
            begin
                queue_load($urandom_range(0, NVERT - 1), random_row());
            end
            else if (pick == 5)
            begin
                queue_colour(MODE_UNUSED, cand, rand64());
            end
            else if (pick < 13)
            begin
                queue_colour(gcco_pkg::MODE_PLAIN, cand, rand64());
            end
            else
            begin
                queue_colour(gcco_pkg::MODE_CONNECTED, cand, random_allowed(cand));
            end
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid)
        begin
            @(negedge clk);
        end
        while (expected_order.size() != 0)
        begin
            @(negedge clk);
        end
        // Let any straggling result show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d row loads and %0d colourings (%0d empty); %0d results checked.",
                 loads_done, colourings, empty_sets, results_seen);
        $display("Highest colour class seen: %0d; mismatches: %0d.", top_colour, mismatches);
        if (mismatches == 0 && expected_order.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
